// File: src/bqe_pkg.sv
// Package for the biquad cascade equalizer: defaults, microcode word and program ROM.
package bqe_pkg;

  localparam int unsigned SECTIONS_DEF    = 3;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEF_BITS_DEF   = 20;

  // program counter
  localparam int unsigned STEP_W = 3;

  // coefficient / operand pair used by a multiply step
  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } tap_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_e;

  typedef struct packed {
    logic              mul;   // register a new product
    tap_e              tap;   // coefficient and operand for the product
    acc_e              acc;   // what to do with the previous product
    logic              fin;   // round, saturate and retire the section
    logic              jmp;   // jump to tgt while sections remain
    logic              eop;   // last word of the program
    logic [STEP_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic   active;  // datapath takes this word this cycle
    logic   done;    // final section retires, result ready
    uword_t w;
  } seq_t;

  localparam logic [STEP_W-1:0] U_B0  = STEP_W'(0);
  localparam logic [STEP_W-1:0] U_B1  = STEP_W'(1);
  localparam logic [STEP_W-1:0] U_B2  = STEP_W'(2);
  localparam logic [STEP_W-1:0] U_A1  = STEP_W'(3);
  localparam logic [STEP_W-1:0] U_A2  = STEP_W'(4);
  localparam logic [STEP_W-1:0] U_FIN = STEP_W'(5);

  // One section: five products, each accumulated from the product register by the word after it, close with round.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul: 1'b0, tap: TAP_B0, acc: ACC_HOLD, fin: 1'b0,
          jmp: 1'b0, eop: 1'b0, tgt: U_B0};
    case (step)
      U_B0: begin
        w.mul = 1'b1;
        w.tap = TAP_B0;
      end
      U_B1: begin
        w.mul = 1'b1;
        w.tap = TAP_B1;
        w.acc = ACC_LOAD;
      end
      U_B2: begin
        w.mul = 1'b1;
        w.tap = TAP_B2;
        w.acc = ACC_ADD;
      end
      U_A1: begin
        w.mul = 1'b1;
        w.tap = TAP_A1;
        w.acc = ACC_ADD;
      end
      U_A2: begin
        w.mul = 1'b1;
        w.tap = TAP_A2;
        w.acc = ACC_SUB;
      end
      U_FIN: begin
        w.acc = ACC_SUB;
        w.fin = 1'b1;
        w.jmp = 1'b1;
        w.eop = 1'b1;
        w.tgt = U_B0;
      end
      default: begin
        w.eop = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/bqe_seq.sv
// Microcode sequencer: step counter, section counter and program ROM lookup.
module bqe_seq
  import bqe_pkg::*;
#(
  parameter int unsigned SECTIONS = SECTIONS_DEF,
  localparam int unsigned SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             hold_i,   // result register still full
  output logic             busy_o,
  output seq_t             seq_o,
  output logic [SEC_W-1:0] sec_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  uword_t            w;
  logic              last_sec;
  logic              active;
  logic              take_jmp;

  assign w        = ucode(step_q);
  assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
  // only the retiring step of the last section waits on the result register
  assign active   = busy_q && !(w.eop && last_sec && hold_i);
  assign take_jmp = w.jmp && !last_sec;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    sec_d  = sec_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = U_B0;
        sec_d  = '0;
      end
    end else if (active) begin
      if (take_jmp) begin
        step_d = w.tgt;
        sec_d  = sec_q + SEC_W'(1);
      end else if (w.eop) begin
        busy_d = 1'b0;
        step_d = U_B0;
        sec_d  = '0;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= U_B0;
      sec_q  <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      sec_q  <= sec_d;
    end
  end

  assign busy_o       = busy_q;
  assign sec_o        = sec_q;
  assign seq_o.active = active;
  assign seq_o.done   = active && w.eop && !take_jmp;
  assign seq_o.w      = w;

endmodule

// File: src/bqe_dp.sv
// Datapath: history registers, shared multiplier, accumulator, round and saturate.
module bqe_dp
  import bqe_pkg::*;
#(
  parameter int unsigned SECTIONS    = SECTIONS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF,
  localparam int unsigned SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1,
  localparam int unsigned FF_W       = 3 * COEF_BITS,
  localparam int unsigned FB_W       = 2 * COEF_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  input  logic [SECTIONS-1:0][FF_W-1:0]      ff_i,
  input  logic [SECTIONS-1:0][FB_W-1:0]      fb_i,
  input  seq_t                               seq_i,
  input  logic [SEC_W-1:0]                   sec_i,
  output logic [SAMPLE_BITS-1:0]             y_o,
  output logic                               clip_o
);

  localparam int unsigned ROWS   = SECTIONS + 1;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned FRAC   = COEF_BITS - 4;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] HI  = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO  = -(ACC_W'(1) << (SAMPLE_BITS - 1));

  // row 0: input history; row s+1: output history of section s. [0] = newest
  logic [ROWS-1:0][1:0][SAMPLE_BITS-1:0] hist_q;
  logic [SAMPLE_BITS-1:0]         cur_q;   // input of the running section
  logic                           clip_q;
  logic signed [PROD_W-1:0]       prod_q, prod_d;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [ACC_W-1:0]        prod_x, fin_sum, shifted;
  logic [ROW_W-1:0]               row, row_own;
  logic [SAMPLE_BITS-1:0]         opnd;
  logic [COEF_BITS-1:0]           coef;
  logic [FF_W-1:0]                ff_sel;
  logic [FB_W-1:0]                fb_sel;
  logic                           is_y, sat, last_sec, retire;
  logic [SAMPLE_BITS-1:0]         y_new;

  assign is_y    = (seq_i.w.tap == TAP_A1) || (seq_i.w.tap == TAP_A2);
  assign row     = ROW_W'(sec_i) + ROW_W'(is_y);
  assign row_own = ROW_W'(sec_i) + ROW_W'(1);
  assign ff_sel  = ff_i[sec_i];
  assign fb_sel  = fb_i[sec_i];

  always_comb begin
    case (seq_i.w.tap)
      TAP_B0: begin
        opnd = cur_q;
        coef = ff_sel[0 +: COEF_BITS];
      end
      TAP_B1: begin
        opnd = hist_q[row][0];
        coef = ff_sel[COEF_BITS +: COEF_BITS];
      end
      TAP_B2: begin
        opnd = hist_q[row][1];
        coef = ff_sel[2*COEF_BITS +: COEF_BITS];
      end
      TAP_A1: begin
        opnd = hist_q[row][0];
        coef = fb_sel[0 +: COEF_BITS];
      end
      TAP_A2: begin
        opnd = hist_q[row][1];
        coef = fb_sel[COEF_BITS +: COEF_BITS];
      end
      default: begin
        opnd = '0;
        coef = '0;
      end
    endcase
  end

  assign prod_d  = $signed(opnd) * $signed(coef);
  assign prod_x  = ACC_W'(prod_q);

  // last product folds in here, then round half up by arithmetic shift
  assign fin_sum = acc_q - prod_x;
  assign shifted = fin_sum >>> FRAC;

  always_comb begin
    sat = 1'b0;
    if (shifted > HI) begin
      y_new = HI[SAMPLE_BITS-1:0];
      sat   = 1'b1;
    end else if (shifted < LO) begin
      y_new = LO[SAMPLE_BITS-1:0];
      sat   = 1'b1;
    end else begin
      y_new = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign last_sec = (sec_i == SEC_W'(SECTIONS - 1));
  assign retire   = seq_i.active && seq_i.w.fin;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cur_q <= sample_i;
    end else if (retire) begin
      cur_q <= y_new;
    end
    if (seq_i.active && seq_i.w.mul) begin
      prod_q <= prod_d;
    end
    if (seq_i.active) begin
      case (seq_i.w.acc)
        ACC_LOAD: acc_q <= RND + prod_x;
        ACC_ADD:  acc_q <= acc_q + prod_x;
        ACC_SUB:  acc_q <= acc_q - prod_x;
        default:  acc_q <= acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
      hist_q <= '0;
    end else begin
      if (load_i) begin
        clip_q <= 1'b0;
      end else if (retire && sat) begin
        clip_q <= 1'b1;
      end
      // section s is done with its inputs' history; the next one needs its own
      if (retire) begin
        for (int r = 0; r < ROWS; r++) begin
          if (ROW_W'(r) == ROW_W'(sec_i)) begin
            hist_q[r][1] <= hist_q[r][0];
            hist_q[r][0] <= cur_q;
          end
          if (last_sec && (ROW_W'(r) == row_own)) begin
            hist_q[r][1] <= hist_q[r][0];
            hist_q[r][0] <= y_new;
          end
        end
      end
    end
  end

  assign y_o    = y_new;
  assign clip_o = clip_q || sat;

endmodule

// File: src/biquad_cascade_equalizer.sv
// Top level of the biquad cascade equalizer: config registers, control, result register.
// Each sample runs every section in turn; the result register loads when the last section retires.
// A new sample is taken only while the sequencer is idle; one shared multiplier runs the
//   six-word microprogram once per section (five products plus a round/saturate step).
// The result register frees the input side: a new sample is taken while a result waits.
// Reset: coefficients go to b0 = 1.0, all else 0 (pass-through); histories clear at once.
module biquad_cascade_equalizer
  import bqe_pkg::*;
#(
  parameter int unsigned SECTIONS    = SECTIONS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = COEF_BITS_DEF,
  localparam int unsigned TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned FF_W       = 3 * COEF_BITS,
  localparam int unsigned FB_W       = 2 * COEF_BITS,
  localparam int unsigned IDX_W      = $clog2(2 * SECTIONS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // sample_in, zero padded
  // result beats
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // sample_out, zero padded
  output logic               m_axis_tuser,   // clipped
  // coefficient writes: index 2s = b0..b2 of section s, 2s+1 = a1,a2
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [FF_W-1:0]    cfg_data_i
);

  localparam int unsigned SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [FF_W-1:0] FF_RST = FF_W'(1) << (COEF_BITS - 4);

  logic [SECTIONS-1:0][FF_W-1:0] ff_q;
  logic [SECTIONS-1:0][FB_W-1:0] fb_q;
  logic                          busy;
  logic                          accept;
  logic                          hold;
  seq_t                          seq;
  logic [SEC_W-1:0]              sec;
  logic [SAMPLE_BITS-1:0]        y;
  logic                          clip;
  logic                          out_vld_q;
  logic [SAMPLE_BITS-1:0]        out_smp_q;
  logic                          out_clip_q;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  // last step stalls only while an older result is still unclaimed
  assign hold          = out_vld_q && !m_axis_tready;

  // coefficient registers; indexes past the last section fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SECTIONS; s++) begin
        ff_q[s] <= FF_RST;
        fb_q[s] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int s = 0; s < SECTIONS; s++) begin
        if (cfg_idx_i == IDX_W'(2 * s)) begin
          ff_q[s] <= cfg_data_i;
        end
        if (cfg_idx_i == IDX_W'(2 * s + 1)) begin
          fb_q[s] <= cfg_data_i[FB_W-1:0];
        end
      end
    end
  end

  bqe_seq #(
    .SECTIONS (SECTIONS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .hold_i  (hold),
    .busy_o  (busy),
    .seq_o   (seq),
    .sec_o   (sec)
  );

  bqe_dp #(
    .SECTIONS    (SECTIONS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .ff_i     (ff_q),
    .fb_i     (fb_q),
    .seq_i    (seq),
    .sec_i    (sec),
    .y_o      (y),
    .clip_o   (clip)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (seq.done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.done) begin
      out_smp_q  <= y;
      out_clip_q <= clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'(out_smp_q);
  assign m_axis_tuser  = out_clip_q;

endmodule
